// File: sv/ctc_greedy_decoder_macros.svh
// ----------------------------------------------------------------------------
// CTC greedy decoder assertion macros
// Concurrent assertion helpers shared by the decoder RTL; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef CTC_GREEDY_DECODER_MACROS_SVH
`define CTC_GREEDY_DECODER_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define CTCGD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("CTC decoder assertion failed");
// Condition must never be true at a rising clock edge outside reset.
`define CTCGD_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("CTC decoder forbidden condition seen");
`else
`define CTCGD_ASSERT(lbl, clk, rstn, prop)
`define CTCGD_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// File: sv/ctcgd_pkg.sv
// ----------------------------------------------------------------------------
// CTC greedy decoder package
// Shared constants, register indexes and the types passed between stages.
// ----------------------------------------------------------------------------
package ctcgd_pkg;

  localparam int unsigned MaxClassesDflt = 128;
  localparam int unsigned MaxStepsDflt   = 32;

  localparam int unsigned ScoreW = 8;
  localparam int unsigned LabelW = 7;
  localparam int unsigned NclsW  = 8;
  localparam int unsigned NstpW  = 6;

  localparam logic [NclsW-1:0]  RstNumClasses = 8'd68;
  localparam logic [NstpW-1:0]  RstNumSteps   = 6'd24;
  localparam logic [LabelW-1:0] RstBlankIndex = 7'd67;

  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    RegNumClasses = 2'd0,
    RegNumSteps   = 2'd1,
    RegBlankIndex = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [NclsW-1:0]  class_cnt;
    logic [NstpW-1:0]  num_steps;
    logic [LabelW-1:0] blank_index;
  } cfg_t;

  // One finished timestep as handed from the front to the back.
  typedef struct packed {
    logic [LabelW-1:0] cls;
    logic              first;
    logic              fin;
  } step_rec_t;

endpackage

// File: sv/ctcgd_front.sv
// ----------------------------------------------------------------------------
// CTC greedy decoder front
// Accepts scores, tracks the running arg-max and closes each timestep.
// ----------------------------------------------------------------------------
module ctcgd_front import ctcgd_pkg::*; #(
  parameter int unsigned MAX_CLASSES = MaxClassesDflt,
  parameter int unsigned MAX_STEPS   = MaxStepsDflt
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              in_valid_i,
  input  logic [ScoreW-1:0] score_i,
  input  logic              full_i,
  output logic              push_o,
  output step_rec_t         rec_o
);

  localparam int unsigned CntW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int unsigned StpW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam logic [8:0]  MaxCls = 9'(MAX_CLASSES);
  localparam logic [8:0]  MaxStp = 9'(MAX_STEPS);

  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [StpW-1:0]   step_q, step_d;
  logic [ScoreW-1:0] best_score_q, best_score_d;
  logic [LabelW-1:0] best_class_q, best_class_d;

  logic       accept, better, step_end, fin;
  logic [8:0] ncls, nstp, ncls_raw, nstp_raw;

  always_comb begin
    ncls_raw = 9'(cfg_i.class_cnt);
    nstp_raw = 9'(cfg_i.num_steps);
    if (ncls_raw == 9'd0) begin
      ncls = 9'd1;
    end else if (ncls_raw > MaxCls) begin
      ncls = MaxCls;
    end else begin
      ncls = ncls_raw;
    end
    if (nstp_raw == 9'd0) begin
      nstp = 9'd1;
    end else if (nstp_raw > MaxStp) begin
      nstp = MaxStp;
    end else begin
      nstp = nstp_raw;
    end
  end

  assign accept   = in_valid_i && !full_i;
  assign better   = (cnt_q == '0) || (score_i > best_score_q);
  assign step_end = !((9'(cnt_q) + 9'd1) < ncls);
  assign fin      = (9'(step_q) + 9'd1) >= nstp;

  always_comb begin
    best_score_d = better ? score_i : best_score_q;
    best_class_d = better ? LabelW'(cnt_q) : best_class_q;
    cnt_d        = step_end ? '0 : cnt_q + CntW'(1);
    step_d       = step_q;
    if (step_end) begin
      step_d = fin ? '0 : step_q + StpW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      step_q       <= '0;
      best_score_q <= '0;
      best_class_q <= '0;
    end else if (accept) begin
      cnt_q        <= cnt_d;
      step_q       <= step_d;
      best_score_q <= best_score_d;
      best_class_q <= best_class_d;
    end
  end

  assign push_o      = accept && step_end;
  assign rec_o.cls   = best_class_d;
  assign rec_o.first = (step_q == '0);
  assign rec_o.fin   = fin;

endmodule

// File: sv/ctcgd_queue.sv
// ----------------------------------------------------------------------------
// CTC greedy decoder step queue
// Short FIFO of finished timesteps between the front and the back.
// ----------------------------------------------------------------------------
`include "ctc_greedy_decoder_macros.svh"

module ctcgd_queue import ctcgd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  step_rec_t wdata_i,
  input  logic      pop_i,
  output step_rec_t rdata_o,
  output logic      full_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);

  step_rec_t       mem_q [QueueDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
      end
    end
  end

  `CTCGD_NEVER(a_queue_overflow, clk_i, rst_ni, push_i && full_o && !pop_i)
  `CTCGD_NEVER(a_queue_underflow, clk_i, rst_ni, pop_i && empty_o)
  `CTCGD_ASSERT(a_queue_count, clk_i, rst_ni, count_q <= CntW'(QueueDepth))

endmodule

// File: sv/ctcgd_back.sv
// ----------------------------------------------------------------------------
// CTC greedy decoder back
// Applies the collapse and blank rules and holds the result register.
// ----------------------------------------------------------------------------
`include "ctc_greedy_decoder_macros.svh"

module ctcgd_back import ctcgd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [LabelW-1:0] blank_i,
  input  step_rec_t         rec_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [LabelW-1:0] label_o,
  output logic              label_valid_o,
  output logic              last_o
);

  logic [LabelW-1:0] prev_q;
  logic              out_valid_q, out_valid_d;
  logic [LabelW-1:0] label_q;
  logic              label_valid_q, last_q;

  logic [LabelW-1:0] prev;
  logic              emit, has_result, out_free;

  assign prev       = rec_i.first ? blank_i : prev_q;
  assign emit       = (rec_i.cls != prev) && (rec_i.cls != blank_i);
  assign has_result = emit || rec_i.fin;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign pop_o      = !empty_i && (!has_result || out_free);

  // A new result may replace one that leaves in the same cycle.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (pop_o && has_result) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= RstBlankIndex;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        prev_q <= rec_i.cls;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && has_result) begin
      label_q       <= emit ? rec_i.cls : '0;
      label_valid_q <= emit;
      last_q        <= rec_i.fin;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign label_o       = label_q;
  assign label_valid_o = label_valid_q;
  assign last_o        = last_q;

  `CTCGD_ASSERT(a_result_has_content, clk_i, rst_ni,
                out_valid_q |-> (label_valid_q || last_q))

endmodule

// File: sv/ctc_greedy_decoder.sv
// ----------------------------------------------------------------------------
// CTC greedy decoder
// Streams class scores in, emits collapsed non-blank arg-max labels out.
// Input channel: one 8-bit score per transfer (in_valid_i / in_stall_o),
// one score per class makes a timestep and a set number of timesteps a
// sequence. Output channel: label_o, label_valid_o and last_o per transfer
// (out_valid_o / out_stall_i). A timestep yields a transfer when its arg-max
// class differs from the previous timestep's and is not the blank class;
// the last timestep of a sequence always yields one with last_o set.
// Throughput is one score per cycle while in_stall_o is low. The result of
// the score that closes a timestep passes through the step queue and then
// into the output register. A two-entry queue between front and back lets
// the front keep taking scores while a result waits; once the receiver has
// stalled long enough to fill the queue, in_stall_o rises.
// Registers sit on an APB-style port: the class count at 0x0, the step count
// at 0x4, the blank index at 0x8; pready is always high. Reset restores 68,
// 24 and 67, empties the queue and output register and starts a new sequence.
// ----------------------------------------------------------------------------
module ctc_greedy_decoder import ctcgd_pkg::*; #(
  parameter int unsigned MAX_CLASSES = MaxClassesDflt,
  parameter int unsigned MAX_STEPS   = MaxStepsDflt
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // Score input channel.
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [ScoreW-1:0] score_i,
  // Label output channel.
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [LabelW-1:0] label_o,
  output logic              label_valid_o,
  output logic              last_o
);

  cfg_t      cfg_q;
  logic      wr_en;
  logic      push, pop, full, empty;
  step_rec_t push_rec, pop_rec;

  // Register file. Writes land in the access phase; unused addresses drop.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.class_cnt   <= RstNumClasses;
      cfg_q.num_steps   <= RstNumSteps;
      cfg_q.blank_index <= RstBlankIndex;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        RegNumClasses: cfg_q.class_cnt   <= pwdata[NclsW-1:0];
        RegNumSteps:   cfg_q.num_steps   <= pwdata[NstpW-1:0];
        RegBlankIndex: cfg_q.blank_index <= pwdata[LabelW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegNumClasses: prdata = 32'(cfg_q.class_cnt);
      RegNumSteps:   prdata = 32'(cfg_q.num_steps);
      RegBlankIndex: prdata = 32'(cfg_q.blank_index);
      default:       prdata = '0;
    endcase
  end

  // The front stalls only on a full queue, so its stall is a registered flag.
  assign in_stall_o = full;

  ctcgd_front #(
    .MAX_CLASSES (MAX_CLASSES),
    .MAX_STEPS   (MAX_STEPS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .score_i    (score_i),
    .full_i     (full),
    .push_o     (push),
    .rec_o      (push_rec)
  );

  ctcgd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_rec),
    .pop_i   (pop),
    .rdata_o (pop_rec),
    .full_o  (full),
    .empty_o (empty)
  );

  // The back applies the blank and repeat rules against the live blank index.
  ctcgd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .blank_i       (cfg_q.blank_index),
    .rec_i         (pop_rec),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .label_o       (label_o),
    .label_valid_o (label_valid_o),
    .last_o        (last_o)
  );

endmodule
